// ----- rtl/ttb_pkg.sv -----
package ttb_pkg;

   // Command codes of the request channel
   typedef enum logic [3:0] {
      CMD_TICK          = 4'd0,
      CMD_START_CADENCE = 4'd1,
      CMD_STOP_CADENCE  = 4'd2,
      CMD_LOAD_KEYHOLD  = 4'd3,
      CMD_LOAD_TYPING   = 4'd4,
      CMD_LOAD_DELAY    = 4'd5,
      CMD_LOAD_MODBUS   = 4'd6,
      CMD_CLEAR_FLAGS   = 4'd7,
      CMD_RESET_COUNTER = 4'd8
   } command_type;

   // Control register indexes
   typedef enum logic [1:0] {
      CSR_BEEP_ON_TICKS  = 2'd0,
      CSR_SLOW_OFF_TICKS = 2'd1,
      CSR_FAST_OFF_TICKS = 2'd2,
      CSR_CLICK_TICKS    = 2'd3
   } csr_index_type;

   // Counter selectors for the reset counter command
   localparam logic [15:0] SEL_TENTH     = 16'd0;
   localparam logic [15:0] SEL_PUMP      = 16'd1;
   localparam logic [15:0] SEL_LINK_A    = 16'd2;
   localparam logic [15:0] SEL_LINK_B    = 16'd3;
   localparam logic [15:0] SEL_BACKLIGHT = 16'd4;
   localparam logic [15:0] SEL_FLUSH     = 16'd5;

   // Cadence speed codes
   localparam logic [1:0] SPEED_SLOW = 2'd1;
   localparam logic [1:0] SPEED_FAST = 2'd2;

   // Prescaler reloads and reset values
   localparam logic [3:0] TENTH_RELOAD    = 4'd10;
   localparam logic [5:0] HALF_RELOAD     = 6'd50;
   localparam logic [5:0] HALF_RESET      = 6'd5;
   localparam logic [6:0] SEC_RELOAD      = 7'd100;
   localparam logic [6:0] SEC_RESET       = 7'd10;
   localparam logic [7:0] MODBUS_RESET    = 8'd30;
   localparam logic [7:0] KEYHOLD_CLICK   = 8'd10;

   // Wrap points (last value before the wrap) and restart values
   localparam logic [7:0]  TENTH_LAST     = 8'd249;
   localparam logic [15:0] PUMP_LAST      = 16'd59999;
   localparam logic [14:0] LINK_LAST      = 15'd30999;
   localparam logic [14:0] LINK_B_RESTART = 15'd200;
   localparam logic [6:0]  TICKS_LAST     = 7'd99;
   localparam logic [5:0]  SECONDS_LAST   = 6'd59;
   localparam logic [10:0] MINUTES_LAST   = 11'd1439;

   // Control register reset values
   localparam logic [15:0] BEEP_ON_RESET  = 16'd400;
   localparam logic [15:0] SLOW_OFF_RESET = 16'd5000;
   localparam logic [15:0] FAST_OFF_RESET = 16'd1000;
   localparam logic [7:0]  CLICK_RESET    = 8'd5;

   typedef struct packed {
      command_type command;
      logic [15:0] value;
      logic [1:0]  speed;
      logic        key_held;
      logic        pump_on;
      logic        buzzer_test;
   } req_type;

   typedef struct packed {
      logic        buzzer_level;
      logic        rtc_flag;
      logic        cursor_flag;
      logic        typing_done;
      logic [15:0] delay_remaining;
      logic [7:0]  tenth_count;
      logic [15:0] pump_delay_count;
      logic [14:0] link_count_a;
      logic [14:0] link_count_b;
      logic [14:0] backlight_ticks;
      logic [10:0] flush_minutes;
      logic [7:0]  modbus_wait;
   } rsp_type;

   // Timer bank view that goes into the result, everything but the pin
   typedef struct packed {
      logic        rtc_flag;
      logic        cursor_flag;
      logic        typing_done;
      logic [15:0] delay_remaining;
      logic [7:0]  tenth_count;
      logic [15:0] pump_delay_count;
      logic [14:0] link_count_a;
      logic [14:0] link_count_b;
      logic [14:0] backlight_ticks;
      logic [10:0] flush_minutes;
      logic [7:0]  modbus_wait;
   } tmr_status_type;

   typedef struct packed {
      logic [15:0] beep_on_ticks;
      logic [15:0] slow_off_ticks;
      logic [15:0] fast_off_ticks;
      logic [7:0]  click_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] speed;
      logic       phase_on;
      logic       active;
   } cadence_type;

endpackage

// ----- rtl/ttb_timers.sv -----
module ttb_timers (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    update,
   input  ttb_pkg::req_type        req,
   output logic                    click_start,
   output ttb_pkg::tmr_status_type status_next
);

   logic [3:0]  tenth_pre_ff, tenth_pre_in;
   logic [5:0]  half_pre_ff, half_pre_in;
   logic [6:0]  sec_pre_ff, sec_pre_in;
   logic [15:0] delay_ff, delay_in;
   logic [7:0]  tenth_cnt_ff, tenth_cnt_in;
   logic [15:0] pump_ff, pump_in;
   logic [7:0]  keyhold_ff, keyhold_in;
   logic [7:0]  modbus_ff, modbus_in;
   logic [2:0]  flags_ff, flags_in;
   logic [15:0] typing_ff, typing_in;
   logic [14:0] link_a_ff, link_a_in;
   logic [14:0] link_b_ff, link_b_in;
   logic [14:0] backlight_ff, backlight_in;
   logic [6:0]  fl_ticks_ff, fl_ticks_in;
   logic [5:0]  fl_secs_ff, fl_secs_in;
   logic [10:0] fl_mins_ff, fl_mins_in;
   logic        is_tick;
   logic        tenth_step;

   assign is_tick    = (req.command == ttb_pkg::CMD_TICK);
   assign tenth_step = (tenth_pre_ff == 4'd1);

   // key click starts on the 100 ms step that finds the hold count at ten
   assign click_start = update && is_tick && tenth_step &&
                        (keyhold_ff == ttb_pkg::KEYHOLD_CLICK);

   // Next state of the timer bank for the current command
   always_comb begin
      tenth_pre_in = tenth_pre_ff;
      half_pre_in  = half_pre_ff;
      sec_pre_in   = sec_pre_ff;
      delay_in     = delay_ff;
      tenth_cnt_in = tenth_cnt_ff;
      pump_in      = pump_ff;
      keyhold_in   = keyhold_ff;
      modbus_in    = modbus_ff;
      flags_in     = flags_ff;
      typing_in    = typing_ff;
      link_a_in    = link_a_ff;
      link_b_in    = link_b_ff;
      backlight_in = backlight_ff;
      fl_ticks_in  = fl_ticks_ff;
      fl_secs_in   = fl_secs_ff;
      fl_mins_in   = fl_mins_ff;
      case (req.command)
         ttb_pkg::CMD_TICK: begin
            if (delay_ff != 16'd0) delay_in = delay_ff - 16'd1;

            // 100 ms step
            if (tenth_step) begin
               tenth_pre_in = ttb_pkg::TENTH_RELOAD;
               tenth_cnt_in = (tenth_cnt_ff >= ttb_pkg::TENTH_LAST) ? 8'd1
                                                                    : tenth_cnt_ff + 8'd1;
               pump_in      = (pump_ff >= ttb_pkg::PUMP_LAST) ? 16'd1 : pump_ff + 16'd1;
               if (keyhold_ff != 8'd0) keyhold_in = keyhold_ff - 8'd1;
               if (modbus_ff != 8'd0) modbus_in = modbus_ff - 8'd1;
            end else begin
               tenth_pre_in = tenth_pre_ff - 4'd1;
            end

            // 500 ms and 1 s flags
            if (half_pre_ff == 6'd1) begin
               half_pre_in = ttb_pkg::HALF_RELOAD;
               flags_in[0] = 1'b1;
            end else begin
               half_pre_in = half_pre_ff - 6'd1;
            end
            if (sec_pre_ff == 7'd1) begin
               sec_pre_in  = ttb_pkg::SEC_RELOAD;
               flags_in[1] = 1'b1;
            end else begin
               sec_pre_in = sec_pre_ff - 7'd1;
            end

            // typing delay pauses while a key is held
            if ((typing_ff != 16'd0) && !req.key_held) begin
               typing_in = typing_ff - 16'd1;
               if (typing_ff == 16'd1) flags_in[2] = 1'b1;
            end

            link_a_in    = (link_a_ff >= ttb_pkg::LINK_LAST) ? 15'd1 : link_a_ff + 15'd1;
            link_b_in    = (link_b_ff >= ttb_pkg::LINK_LAST) ? ttb_pkg::LINK_B_RESTART
                                                             : link_b_ff + 15'd1;
            backlight_in = (backlight_ff >= ttb_pkg::LINK_LAST) ? 15'd1
                                                                : backlight_ff + 15'd1;

            // pump run clock: ticks, seconds, minutes
            if (req.pump_on) begin
               if (fl_ticks_ff >= ttb_pkg::TICKS_LAST) begin
                  fl_ticks_in = 7'd0;
                  if (fl_secs_ff >= ttb_pkg::SECONDS_LAST) begin
                     fl_secs_in = 6'd0;
                     fl_mins_in = (fl_mins_ff >= ttb_pkg::MINUTES_LAST) ? 11'd0
                                                                        : fl_mins_ff + 11'd1;
                  end else begin
                     fl_secs_in = fl_secs_ff + 6'd1;
                  end
               end else begin
                  fl_ticks_in = fl_ticks_ff + 7'd1;
               end
            end
         end
         ttb_pkg::CMD_LOAD_KEYHOLD: keyhold_in = req.value[7:0];
         ttb_pkg::CMD_LOAD_TYPING:  typing_in  = req.value;
         ttb_pkg::CMD_LOAD_DELAY:   delay_in   = req.value;
         ttb_pkg::CMD_LOAD_MODBUS:  modbus_in  = req.value[7:0];
         ttb_pkg::CMD_CLEAR_FLAGS:  flags_in   = flags_ff & ~req.value[2:0];
         ttb_pkg::CMD_RESET_COUNTER: begin
            if (req.value == ttb_pkg::SEL_TENTH) tenth_cnt_in = 8'd0;
            if (req.value == ttb_pkg::SEL_PUMP) pump_in = 16'd0;
            if (req.value == ttb_pkg::SEL_LINK_A) link_a_in = 15'd0;
            if (req.value == ttb_pkg::SEL_LINK_B) link_b_in = 15'd0;
            if (req.value == ttb_pkg::SEL_BACKLIGHT) backlight_in = 15'd0;
            if (req.value == ttb_pkg::SEL_FLUSH) begin
               fl_ticks_in = 7'd0;
               fl_secs_in  = 6'd0;
               fl_mins_in  = 11'd0;
            end
         end
         default: begin
         end
      endcase
   end

   // Timer bank registers, updated on each request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         tenth_pre_ff <= ttb_pkg::TENTH_RELOAD;
         half_pre_ff  <= ttb_pkg::HALF_RESET;
         sec_pre_ff   <= ttb_pkg::SEC_RESET;
         delay_ff     <= 16'd0;
         tenth_cnt_ff <= 8'd0;
         pump_ff      <= 16'd0;
         keyhold_ff   <= 8'd0;
         modbus_ff    <= ttb_pkg::MODBUS_RESET;
         flags_ff     <= 3'd0;
         typing_ff    <= 16'd0;
         link_a_ff    <= 15'd0;
         link_b_ff    <= 15'd0;
         backlight_ff <= 15'd0;
         fl_ticks_ff  <= 7'd0;
         fl_secs_ff   <= 6'd0;
         fl_mins_ff   <= 11'd0;
      end else if (update) begin
         tenth_pre_ff <= tenth_pre_in;
         half_pre_ff  <= half_pre_in;
         sec_pre_ff   <= sec_pre_in;
         delay_ff     <= delay_in;
         tenth_cnt_ff <= tenth_cnt_in;
         pump_ff      <= pump_in;
         keyhold_ff   <= keyhold_in;
         modbus_ff    <= modbus_in;
         flags_ff     <= flags_in;
         typing_ff    <= typing_in;
         link_a_ff    <= link_a_in;
         link_b_ff    <= link_b_in;
         backlight_ff <= backlight_in;
         fl_ticks_ff  <= fl_ticks_in;
         fl_secs_ff   <= fl_secs_in;
         fl_mins_ff   <= fl_mins_in;
      end
   end

   // values after this command, for the result register
   assign status_next.rtc_flag         = flags_in[0];
   assign status_next.cursor_flag      = flags_in[1];
   assign status_next.typing_done      = flags_in[2];
   assign status_next.delay_remaining  = delay_in;
   assign status_next.tenth_count      = tenth_cnt_in;
   assign status_next.pump_delay_count = pump_in;
   assign status_next.link_count_a     = link_a_in;
   assign status_next.link_count_b     = link_b_in;
   assign status_next.backlight_ticks  = backlight_in;
   assign status_next.flush_minutes    = fl_mins_in;
   assign status_next.modbus_wait      = modbus_in;

endmodule

// ----- rtl/ttb_buzzer.sv -----
module ttb_buzzer (
   input  logic             clock,
   input  logic             reset,
   input  logic             update,
   input  ttb_pkg::req_type req,
   input  ttb_pkg::cfg_type cfg,
   input  logic             click_start,
   output logic             pin_next
);

   logic [7:0]           click_cnt_ff, click_cnt_in;
   logic                 click_en_ff, click_en_in;
   ttb_pkg::cadence_type cad_ff, cad_in;
   logic [15:0]          cad_cnt_ff, cad_cnt_in;
   logic                 pin_ff, pin_in;

   // Click and cadence next state
   always_comb begin
      click_cnt_in = click_cnt_ff;
      click_en_in  = click_en_ff;
      cad_in       = cad_ff;
      cad_cnt_in   = cad_cnt_ff;
      pin_in       = pin_ff;
      if (click_start) begin
         click_cnt_in = cfg.click_ticks;
         click_en_in  = 1'b1;
      end
      case (req.command)
         ttb_pkg::CMD_TICK: begin
            if (!req.buzzer_test) begin
               if (!click_en_in) begin
                  pin_in = 1'b0;
               end else begin
                  // click runs down; its end drops the pin and the enable
                  if (click_cnt_in != 8'd0) begin
                     click_cnt_in = click_cnt_in - 8'd1;
                     pin_in       = 1'b1;
                     if (click_cnt_in == 8'd0) begin
                        pin_in      = 1'b0;
                        click_en_in = 1'b0;
                     end
                  end
                  // cadence still steps on the tick that ends the click
                  if (cad_ff.active) begin
                     cad_cnt_in = cad_cnt_ff - 16'd1;
                     if (cad_cnt_in == 16'd0) begin
                        if (cad_ff.phase_on) begin
                           cad_in.phase_on = 1'b0;
                           pin_in          = 1'b0;
                           if (cad_ff.speed == ttb_pkg::SPEED_SLOW)
                              cad_cnt_in = cfg.slow_off_ticks;
                           else if (cad_ff.speed == ttb_pkg::SPEED_FAST)
                              cad_cnt_in = cfg.fast_off_ticks;
                        end else begin
                           cad_in.phase_on = 1'b1;
                           pin_in          = 1'b1;
                           cad_cnt_in      = cfg.beep_on_ticks;
                        end
                     end
                  end
               end
            end
         end
         ttb_pkg::CMD_START_CADENCE: begin
            if (click_en_ff) begin
               cad_in.active   = 1'b1;
               cad_in.phase_on = 1'b1;
               cad_in.speed    = req.speed;
               cad_cnt_in      = cfg.beep_on_ticks;
               pin_in          = 1'b1;
            end
         end
         ttb_pkg::CMD_STOP_CADENCE: begin
            cad_in = '0;
            pin_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         click_cnt_ff <= 8'd0;
         click_en_ff  <= 1'b0;
         cad_ff       <= '0;
         cad_cnt_ff   <= 16'd0;
         pin_ff       <= 1'b0;
      end else if (update) begin
         click_cnt_ff <= click_cnt_in;
         click_en_ff  <= click_en_in;
         cad_ff       <= cad_in;
         cad_cnt_ff   <= cad_cnt_in;
         pin_ff       <= pin_in;
      end
   end

   assign pin_next = pin_in;

endmodule

// ----- rtl/tick_timer_bank_with_buzzer_cadence.sv -----
// Tick timer bank with buzzer cadence.
// Request channel (req_valid/req_ready/req_data) carries one command per
// transfer: a 10 ms tick, a cadence start or stop, a counter load, a flag
// clear or a counter reset. Every request gives exactly one response on the
// rsp_ channel with the buzzer pin level, sticky flags and counter values as
// they stand after the command.
// The response is registered, valid in the cycle after the request transfer.
// Throughput: one request per cycle while responses are taken; all the work
// is a single pass of counter logic into the response register, which also
// parts the channels. When the receiver stalls, the response register holds
// its data and req_ready stays low until that response is taken; a response
// being taken in the same cycle frees the register for the next request.
// Control registers (csr_ channel, always ready) set the beep on length, the
// slow and fast off lengths and the key click length; write them while idle.
// Synchronous reset restores all timers, flags and control registers to their
// defaults and leaves the response channel empty.
module tick_timer_bank_with_buzzer_cadence (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ttb_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ttb_pkg::rsp_type       rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  ttb_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_data
);

   ttb_pkg::cfg_type        cfg_ff;
   ttb_pkg::tmr_status_type status_next;
   ttb_pkg::rsp_type        rsp_data_ff, rsp_data_in;
   logic                    rsp_valid_ff;
   logic                    req_xfer;
   logic                    click_start;
   logic                    pin_next;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.beep_on_ticks  <= ttb_pkg::BEEP_ON_RESET;
         cfg_ff.slow_off_ticks <= ttb_pkg::SLOW_OFF_RESET;
         cfg_ff.fast_off_ticks <= ttb_pkg::FAST_OFF_RESET;
         cfg_ff.click_ticks    <= ttb_pkg::CLICK_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            ttb_pkg::CSR_BEEP_ON_TICKS:  cfg_ff.beep_on_ticks  <= csr_data;
            ttb_pkg::CSR_SLOW_OFF_TICKS: cfg_ff.slow_off_ticks <= csr_data;
            ttb_pkg::CSR_FAST_OFF_TICKS: cfg_ff.fast_off_ticks <= csr_data;
            ttb_pkg::CSR_CLICK_TICKS:    cfg_ff.click_ticks    <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   ttb_timers u_timers (
      .clock       (clock),
      .reset       (reset),
      .update      (req_xfer),
      .req         (req_data),
      .click_start (click_start),
      .status_next (status_next)
   );

   ttb_buzzer u_buzzer (
      .clock       (clock),
      .reset       (reset),
      .update      (req_xfer),
      .req         (req_data),
      .cfg         (cfg_ff),
      .click_start (click_start),
      .pin_next    (pin_next)
   );

   // Response assembly
   always_comb begin
      rsp_data_in.buzzer_level     = pin_next;
      rsp_data_in.rtc_flag         = status_next.rtc_flag;
      rsp_data_in.cursor_flag      = status_next.cursor_flag;
      rsp_data_in.typing_done      = status_next.typing_done;
      rsp_data_in.delay_remaining  = status_next.delay_remaining;
      rsp_data_in.tenth_count      = status_next.tenth_count;
      rsp_data_in.pump_delay_count = status_next.pump_delay_count;
      rsp_data_in.link_count_a     = status_next.link_count_a;
      rsp_data_in.link_count_b     = status_next.link_count_b;
      rsp_data_in.backlight_ticks  = status_next.backlight_ticks;
      rsp_data_in.flush_minutes    = status_next.flush_minutes;
      rsp_data_in.modbus_wait      = status_next.modbus_wait;
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
